// ===== design/rgbh_pkg.sv =====
package rgbh_pkg;

   localparam int BIN_COUNT = 256;
   localparam int BIN_BITS = $clog2(BIN_COUNT);
   localparam int LANES = 4;
   localparam int CFG_BITS = 15;
   localparam int PROD_BITS = 2 * CFG_BITS;
   // wide enough for the frame product and any count width up to 32
   localparam int CMP_BITS = 33;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CMD_BITS = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_ACCUM = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DROP = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // per-lane bin memory control
   typedef struct packed {
      logic rd_en;
      logic [BIN_BITS-1:0] addr;
      logic inc;
      logic clear;
   } lane_ctrl_type;

   // result register control
   typedef struct packed {
      logic load;
      logic show_counts;
      logic [STATUS_BITS-1:0] status;
   } merge_ctrl_type;

endpackage

// ===== design/rgbh_req_if.sv =====
interface rgbh_req_if;
   import rgbh_pkg::*;

   logic valid;
   logic ready;
   logic [CMD_BITS-1:0] command;
   logic [31:0] pixel_word;
   logic [BIN_BITS-1:0] bin_index;

   modport source (output valid, output command, output pixel_word, output bin_index,
                   input ready);
   modport sink (input valid, input command, input pixel_word, input bin_index,
                 output ready);
endinterface

// ===== design/rgbh_rsp_if.sv =====
interface rgbh_rsp_if #(parameter int COUNT_BITS = 28);
   import rgbh_pkg::*;

   logic valid;
   logic ready;
   logic [COUNT_BITS-1:0] count_red;
   logic [COUNT_BITS-1:0] count_green;
   logic [COUNT_BITS-1:0] count_blue;
   logic [COUNT_BITS-1:0] count_alpha;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output count_red, output count_green, output count_blue,
                   output count_alpha, output status, input ready);
   modport sink (input valid, input count_red, input count_green, input count_blue,
                 input count_alpha, input status, output ready);
endinterface

// ===== design/rgbh_lane.sv =====
module rgbh_lane #(
   parameter int COUNT_BITS = 28
) (
   input  logic clock,
   input  logic reset,
   input  rgbh_pkg::lane_ctrl_type ctrl,
   output logic [COUNT_BITS-1:0] count
);
   import rgbh_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] mem_ff [BIN_COUNT];
   logic [BIN_COUNT-1:0] written_ff;
   logic [BIN_BITS-1:0] addr_ff;
   logic [COUNT_BITS-1:0] data_ff;
   logic hit_ff;
   logic wr_en;

   // never-written bins read as zero
   assign count = hit_ff ? data_ff : '0;
   assign wr_en = ctrl.inc && (count != COUNT_MAX);

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         addr_ff <= ctrl.addr;
         data_ff <= mem_ff[ctrl.addr];
         hit_ff <= written_ff[ctrl.addr];
      end
      if (wr_en) begin
         mem_ff[addr_ff] <= count + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[addr_ff] <= 1'b1;
      end
   end

endmodule

// ===== design/rgbh_merge.sv =====
module rgbh_merge #(
   parameter int COUNT_BITS = 28
) (
   input  logic clock,
   input  logic reset,
   input  rgbh_pkg::merge_ctrl_type ctrl,
   input  logic [rgbh_pkg::LANES-1:0][COUNT_BITS-1:0] lane_counts,
   output logic slot_free,
   rgbh_rsp_if.source rsp_chan
);
   import rgbh_pkg::*;

   logic valid_ff;
   logic [LANES-1:0][COUNT_BITS-1:0] counts_ff;
   logic [LANES-1:0][COUNT_BITS-1:0] counts_in;
   logic [STATUS_BITS-1:0] status_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;
   assign counts_in = ctrl.show_counts ? lane_counts : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         counts_ff <= counts_in;
         status_ff <= ctrl.status;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.count_red = counts_ff[0];
   assign rsp_chan.count_green = counts_ff[1];
   assign rsp_chan.count_blue = counts_ff[2];
   assign rsp_chan.count_alpha = counts_ff[3];
   assign rsp_chan.status = status_ff;

endmodule

// ===== design/rgba_channel_histogram.sv =====
// four 256-bin histograms (red, green, blue, alpha) built from packed 32-bit
// pixels, red in the top byte. accumulate bumps one bin per channel, read
// returns the four counts of one bin, clear empties every bin and restarts the
// frame. every command beat yields exactly one response beat. each channel
// lane owns a bin memory. the accept edge reads the bins; once the response
// register has room, the commit edge does the saturating write-back and loads
// the response register. this read-modify-write means a command is taken
// only after the one before it has committed; a waiting response does not
// stop the next command from being taken. once image_width * image_height
// pixels (clamped to the counter maximum) have been seen, the pixel that
// reaches it reports status done and later pixels leave the bins alone and
// report status drop until a clear. bins come out of reset and clear as zero
// at once, no sweep needed. csr writes belong only to idle periods
module rgba_channel_histogram #(
   parameter int COUNT_BITS = 28
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic [rgbh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rgbh_pkg::CFG_BITS-1:0] csr_write_data,
   rgbh_req_if.sink req_chan,
   rgbh_rsp_if.source rsp_chan
);
   import rgbh_pkg::*;

   localparam logic [CMP_BITS-1:0] COUNT_MAX_EXT = CMP_BITS'({COUNT_BITS{1'b1}});

   // control state
   state_type state_ff, state_in;
   logic [CMD_BITS-1:0] cmd_ff;
   logic [COUNT_BITS-1:0] pixels_seen_ff, pixels_seen_in;

   // configuration and derived frame size
   logic [CFG_BITS-1:0] width_ff, height_ff;
   logic [PROD_BITS-1:0] product;
   logic [CMP_BITS-1:0] target_ff, target_in;

   logic accept, commit, slot_free;
   logic frame_full, frame_done;
   logic [CMP_BITS-1:0] seen_ext;

   lane_ctrl_type lane_ctrl [LANES];
   logic [LANES-1:0][COUNT_BITS-1:0] lane_counts;
   merge_ctrl_type merge_ctrl;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign commit = (state_ff == ST_UPDATE) && slot_free;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_BITS'(1);
         height_ff <= CFG_BITS'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: width_ff <= csr_write_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // frame size, clamped to what the pixel counter can hold
   assign product = PROD_BITS'(width_ff) * PROD_BITS'(height_ff);
   assign target_in = (CMP_BITS'(product) > COUNT_MAX_EXT) ? COUNT_MAX_EXT
                                                           : CMP_BITS'(product);

   always_ff @(posedge clock) begin
      target_ff <= target_in;
   end

   // per-channel lanes: address is the channel byte or the requested bin
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      always_comb begin
         lane_ctrl[k].rd_en = accept;
         lane_ctrl[k].addr = (req_chan.command == CMD_READ) ? req_chan.bin_index
                             : req_chan.pixel_word[8*(LANES-1-k) +: 8];
         lane_ctrl[k].inc = commit && (cmd_ff == CMD_ACCUM) && !frame_full;
         lane_ctrl[k].clear = commit && (cmd_ff == CMD_CLEAR);
      end

      rgbh_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .ctrl(lane_ctrl[k]),
         .count(lane_counts[k])
      );
   end

   // frame bookkeeping
   assign seen_ext = CMP_BITS'(pixels_seen_ff);
   assign frame_full = (seen_ext >= target_ff);
   assign frame_done = ((seen_ext + CMP_BITS'(1)) == target_ff);

   always_comb begin
      pixels_seen_in = pixels_seen_ff;
      merge_ctrl.load = commit;
      merge_ctrl.show_counts = (cmd_ff == CMD_READ);
      merge_ctrl.status = STATUS_OK;
      if (commit) begin
         unique case (cmd_ff)
            CMD_ACCUM: begin
               if (frame_full) begin
                  merge_ctrl.status = STATUS_DROP;
               end else begin
                  pixels_seen_in = pixels_seen_ff + COUNT_BITS'(1);
                  merge_ctrl.status = frame_done ? STATUS_DONE : STATUS_OK;
               end
            end
            CMD_CLEAR: pixels_seen_in = '0;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pixels_seen_ff <= '0;
      end else begin
         state_ff <= state_in;
         pixels_seen_ff <= pixels_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.command;
      end
   end

   rgbh_merge #(
      .COUNT_BITS(COUNT_BITS)
   ) u_merge (
      .clock(clock),
      .reset(reset),
      .ctrl(merge_ctrl),
      .lane_counts(lane_counts),
      .slot_free(slot_free),
      .rsp_chan(rsp_chan)
   );

`ifndef ASSERT_OFF
   // a clear always restarts the frame counter
   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == CMD_CLEAR) |=> (pixels_seen_ff == '0))
      else $error("pixel counter not zero after clear");

   // a dropped pixel leaves the frame counter alone
   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == CMD_ACCUM && frame_full) |=> $stable(pixels_seen_ff))
      else $error("pixel counter moved on a dropped pixel");

   // only read responses carry counts, and they carry status ok
   a_status_no_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |->
      (rsp_chan.count_red == '0 && rsp_chan.count_green == '0 &&
       rsp_chan.count_blue == '0 && rsp_chan.count_alpha == '0))
      else $error("counts present on a non-read response");

   // the frame counter never runs past the frame size
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == CMD_ACCUM && !frame_full) |=> (seen_ext <= $past(target_ff)))
      else $error("pixel counter passed frame size");
`endif

endmodule

// ===== test/rgba_channel_histogram_tb.sv =====
`timescale 1ns / 100ps

module rgba_channel_histogram_tb;
   import rgbh_pkg::*;

   localparam int COUNT_BITS = 28;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   // the one command value the block ignores
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 950;
   localparam int SINK_HOLD_CYCLES = 200;
   localparam int IDLE_SETTLE = 4;
   localparam int CYCLE_LIMIT = 400000;

   // one response beat: four channel counts and the frame status
   typedef struct packed {
      logic [COUNT_BITS-1:0] red;
      logic [COUNT_BITS-1:0] green;
      logic [COUNT_BITS-1:0] blue;
      logic [COUNT_BITS-1:0] alpha;
      logic [STATUS_BITS-1:0] status;
   } bin_response_t;

   // keeps a shadow of the four histograms and the frame counter, and the
   // responses still owed by the block in command order
   class channel_histogram_board;
      bin_response_t awaited_responses[$];
      logic [COUNT_BITS-1:0] bin_counts[LANES][BIN_COUNT];
      logic [COUNT_BITS-1:0] pixels_seen;
      logic [CFG_BITS-1:0] image_width;
      logic [CFG_BITS-1:0] image_height;
      int mismatch_count;

      function new();
         image_width = CFG_BITS'(1);
         image_height = CFG_BITS'(1);
         mismatch_count = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         foreach (bin_counts[lane, slot])
            bin_counts[lane][slot] = '0;
         pixels_seen = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH: image_width = value;
            REG_IMAGE_HEIGHT: image_height = value;
            default: ;
         endcase
      endfunction

      function void note_command(logic [CMD_BITS-1:0] cmd, logic [31:0] px,
                                 logic [BIN_BITS-1:0] bin_sel);
         bin_response_t r;
         longint unsigned target;
         logic [BIN_BITS-1:0] slot;
         int lane;
         r = '0;
         case (cmd)
            CMD_ACCUM: begin
               // frame size clamped to what the pixel counter can hold
               target = longint'(image_width) * longint'(image_height);
               if (target > COUNT_MAX)
                  target = 64'(COUNT_MAX);
               if (pixels_seen >= target) begin
                  r.status = STATUS_DROP;
               end else begin
                  // lane 0 is red in the top byte, lane 3 alpha in the lowest
                  for (lane = 0; lane < LANES; lane++) begin
                     slot = px[31 - 8*lane -: 8];
                     if (bin_counts[lane][slot] != COUNT_MAX)
                        bin_counts[lane][slot]++;
                  end
                  pixels_seen++;
                  r.status = (pixels_seen == target) ? STATUS_DONE : STATUS_OK;
               end
            end
            CMD_READ: begin
               r.red = bin_counts[0][bin_sel];
               r.green = bin_counts[1][bin_sel];
               r.blue = bin_counts[2][bin_sel];
               r.alpha = bin_counts[3][bin_sel];
            end
            CMD_CLEAR: clear_counts();
            default: ;
         endcase
         awaited_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [COUNT_BITS-1:0] want,
                                  logic [COUNT_BITS-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_response(bin_response_t got);
         bin_response_t want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none expected, expected none actual %0h",
                     $time, got);
            mismatch_count++;
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("count_red", want.red, got.red);
         compare_field("count_green", want.green, got.green);
         compare_field("count_blue", want.blue, got.blue);
         compare_field("count_alpha", want.alpha, got.alpha);
         compare_field("status", COUNT_BITS'(want.status), COUNT_BITS'(got.status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0] csr_write_data;
   bit sink_hold_request = 1'b0;
   int items_sent = 0;
   int cycle_count = 0;

   channel_histogram_board board = new();

   rgbh_req_if req_chan ();
   rgbh_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_chan ();

   rgba_channel_histogram #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgba_channel_histogram_tb failed");
         $finish;
      end
   end

   // response monitor: every accepted beat is checked against the oldest
   // outstanding prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response(bin_response_t'{rsp_chan.count_red, rsp_chan.count_green,
                                              rsp_chan.count_blue, rsp_chan.count_alpha,
                                              rsp_chan.status});
   end

   // response sink: stretches of free flow, short random stalls and the odd
   // long stall; one very long hold on request so the block backs up
   initial begin : response_sink
      int span;
      int style;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      forever begin
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
         end else begin
            span = $urandom_range(1, 24);
            style = $urandom_range(0, 9);
            repeat (span) begin
               if (style < 4)
                  rsp_chan.ready <= 1'b1;
               else if (style < 9)
                  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               else
                  rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   // drive one command beat and hold it until the block takes it; valid is
   // left high so a following beat can go out back to back
   task automatic issue_command(input logic [CMD_BITS-1:0] cmd, input logic [31:0] px,
                                input logic [BIN_BITS-1:0] bin_sel);
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.pixel_word <= px;
      req_chan.bin_index <= bin_sel;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_command(cmd, px, bin_sel);
      items_sent++;
   endtask

   // sender idle time: mostly none or a short gap, sometimes a long pause
   task automatic sender_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 11)
         n = 0;
      else if (pick < 18)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(8, 30);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending and wait until every predicted response has come back,
   // plus some settling margin
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.awaited_responses.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // both frame registers, one write per cycle; only called while idle
   task automatic program_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
      csr_write_en <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      board.write_reg(REG_IMAGE_WIDTH, w);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      board.write_reg(REG_IMAGE_HEIGHT, h);
      csr_write_en <= 1'b0;
   endtask

   // one frame: pick a size, usually clear, push pixels with stray reads and
   // unused commands (up to 3 beyond a small frame to hit the drop path), then read back
   task automatic run_random_phase();
      logic [31:0] palette[4];
      logic [31:0] px;
      int kind;
      int w;
      int h;
      int pixels;
      int reads;
      int pick;
      int lane;
      int i;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // zero-sized frame: every pixel dropped
         w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
         h = (w == 0) ? $urandom_range(0, 6) : 0;
      end else if (kind == 1) begin
         w = $urandom_range(16384, 32767);
         h = $urandom_range(16384, 32767);
      end else if (kind == 2) begin
         w = 16384;
         h = 16384;
      end else begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 5);
      end
      wait_idle();
      // now and then keep the old size and, unless a clear follows, carry on the old frame
      if (kind < 17)
         program_frame(CFG_BITS'(w), CFG_BITS'(h));
      else begin
         w = int'(board.image_width);
         h = int'(board.image_height);
      end
      for (i = 0; i < 4; i++)
         palette[i] = $urandom();
      if ($urandom_range(0, 3) != 0) begin
         sender_gap();
         issue_command(CMD_CLEAR, $urandom(), BIN_BITS'($urandom_range(0, 255)));
      end
      if (w * h > 0 && w * h <= 30)
         pixels = w * h + $urandom_range(0, 3);
      else
         pixels = $urandom_range(5, 25);
      for (i = 0; i < pixels; i++) begin
         sender_gap();
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            px = palette[$urandom_range(0, 3)];
            lane = $urandom_range(0, 3);
            issue_command(CMD_READ, $urandom(), px[31 - 8*lane -: 8]);
         end else if (pick == 1) begin
            issue_command(CMD_UNUSED, $urandom(), BIN_BITS'($urandom_range(0, 255)));
         end else begin
            px = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)] : $urandom();
            issue_command(CMD_ACCUM, px, BIN_BITS'($urandom_range(0, 255)));
         end
      end
      reads = $urandom_range(3, 8);
      for (i = 0; i < reads; i++) begin
         sender_gap();
         px = palette[$urandom_range(0, 3)];
         lane = $urandom_range(0, 3);
         if ($urandom_range(0, 4) == 0)
            issue_command(CMD_READ, $urandom(), BIN_BITS'($urandom_range(0, 255)));
         else
            issue_command(CMD_READ, $urandom(), px[31 - 8*lane -: 8]);
      end
   endtask

   initial begin : stimulus
      int i;
      req_chan.valid <= 1'b0;
      req_chan.command <= CMD_ACCUM;
      req_chan.pixel_word <= '0;
      req_chan.bin_index <= '0;
      csr_write_en <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size is 1 x 1: first pixel completes the frame, second drops
      issue_command(CMD_ACCUM, 32'hFFFF_FFFF, 8'h00);
      issue_command(CMD_ACCUM, 32'h0000_0000, 8'hFF);
      issue_command(CMD_READ, 32'h0000_0000, 8'hFF);
      issue_command(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      // unused command: no state change, all zero
      issue_command(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      issue_command(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
      issue_command(CMD_READ, 32'h0000_0000, 8'hFF);

      // zero width: frame counts as already complete
      wait_idle();
      program_frame(15'd0, 15'd5);
      issue_command(CMD_ACCUM, 32'hA5A5_A5A5, 8'h00);

      // largest register values: product clamps to the counter maximum
      wait_idle();
      program_frame(15'h7FFF, 15'h7FFF);
      issue_command(CMD_ACCUM, 32'h0011_2233, 8'h00);
      issue_command(CMD_ACCUM, 32'h0011_2233, 8'h00);
      issue_command(CMD_ACCUM, 32'hFF00_807F, 8'h00);
      issue_command(CMD_READ, 32'h0000_0000, 8'h11);
      issue_command(CMD_READ, 32'h0000_0000, 8'h22);
      issue_command(CMD_READ, 32'h0000_0000, 8'h33);
      issue_command(CMD_READ, 32'h0000_0000, 8'hFF);
      issue_command(CMD_READ, 32'h0000_0000, 8'h7F);
      issue_command(CMD_CLEAR, 32'h0000_0000, 8'h00);

      // 2 x 1 frame right after a clear
      wait_idle();
      program_frame(15'd2, 15'd1);
      issue_command(CMD_ACCUM, 32'h8040_2010, 8'h00);
      issue_command(CMD_ACCUM, 32'h0102_0408, 8'h00);
      issue_command(CMD_ACCUM, 32'h8040_2010, 8'h00);
      issue_command(CMD_READ, 32'h0000_0000, 8'h80);
      issue_command(CMD_READ, 32'h0000_0000, 8'h01);
      issue_command(CMD_CLEAR, 32'h0000_0000, 8'h00);

      // back-pressure: the sink holds off for a long stretch while beats
      // keep coming, so the block fills up and stalls its input
      wait_idle();
      program_frame(15'd4, 15'd4);
      items_sent = 0;
      sink_hold_request = 1'b1;
      for (i = 0; i < 30; i++) begin
         if (i % 5 == 4)
            issue_command(CMD_READ, $urandom(), BIN_BITS'($urandom_range(0, 255)));
         else
            issue_command(CMD_ACCUM, $urandom(), BIN_BITS'($urandom_range(0, 255)));
      end

      while (items_sent < RANDOM_ITEMS)
         run_random_phase();

      wait_idle();
      repeat (20) @(posedge clock);
      if (board.mismatch_count == 0)
         $display("rgba_channel_histogram_tb passed");
      else
         $display("rgba_channel_histogram_tb failed");
      $finish;
   end

endmodule

// ===== rgba_channel_histogram.f =====
design/rgbh_pkg.sv
design/rgbh_req_if.sv
design/rgbh_rsp_if.sv
design/rgbh_lane.sv
design/rgbh_merge.sv
design/rgba_channel_histogram.sv
test/rgba_channel_histogram_tb.sv
